// File: sv/noisy_neighbor_average_pixel_unit_assert.svh
// assertion macros for the noisy neighbor average pixel unit
`ifndef NOISY_NEIGHBOR_AVERAGE_PIXEL_UNIT_ASSERT_SVH
`define NOISY_NEIGHBOR_AVERAGE_PIXEL_UNIT_ASSERT_SVH

// checked only outside reset
`define NNAP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define NNAP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/nnap_pkg.sv
// shared types, register codes and channel math for the pixel unit
package nnap_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHANNEL_ENABLE = 2'd0,
    REG_PIXEL_FORMAT   = 2'd1
  } cfg_reg_t;

  localparam logic FMT_555 = 1'b0;
  localparam logic FMT_565 = 1'b1;

  typedef struct packed {
    logic [2:0] channel_enable;
    logic       pixel_format;
  } cfg_t;

  typedef struct packed {
    logic red;
    logic green;
    logic blue;
  } raise_t;

  // floored average of two fields, stepped by one and clamped to 0..31
  function automatic logic [4:0] noisy_avg(input logic [4:0] a, input logic [4:0] b,
                                           input logic up);
    logic [5:0] sum;
    logic [4:0] avg;
    logic [4:0] res;
    sum = {1'b0, a} + {1'b0, b};
    avg = sum[5:1];
    if (up) begin
      res = (avg == 5'd31) ? 5'd31 : avg + 5'd1;
    end else begin
      res = (avg == 5'd0) ? 5'd0 : avg - 5'd1;
    end
    return res;
  endfunction

endpackage

// File: sv/nnap_line_mem.sv
// one-line delay memory with fill tracking, read-first at the write address
module nnap_line_mem #(
  parameter int LINE_WIDTH = 336
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [15:0] wr_pixel,
  output logic [15:0] above
);
  import nnap_pkg::*;

  localparam int PTR_W = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;

  logic [15:0]      mem [LINE_WIDTH];
  logic [15:0]      rd_data;
  logic [PTR_W-1:0] ptr;
  logic             wrapped;
  logic             rd_filled;

  // old entry comes out the cycle after the request that overwrites it
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rd_data  <= mem[ptr];
      mem[ptr] <= wr_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr       <= '0;
      wrapped   <= 1'b0;
      rd_filled <= 1'b0;
    end else if (wr_en) begin
      rd_filled <= wrapped;
      if (ptr == PTR_W'(LINE_WIDTH - 1)) begin
        ptr     <= '0;
        wrapped <= 1'b1;
      end else begin
        ptr <= ptr + PTR_W'(1);
      end
    end
  end

  // entries not written since reset read as zero
  assign above = rd_filled ? rd_data : 16'h0000;

endmodule

// File: sv/nnap_pixel_mix.sv
// splits both neighbors into fields, averages with noise and repacks
module nnap_pixel_mix (
  input  nnap_pkg::cfg_t   cfg,
  input  nnap_pkg::raise_t raise,
  input  logic [15:0]      above,
  input  logic [15:0]      left,
  output logic [15:0]      mixed
);
  import nnap_pkg::*;

  logic [4:0] above_r, above_g, left_r, left_g;
  logic [4:0] r, g, b;

  always_comb begin
    unique case (cfg.pixel_format)
      FMT_565: begin
        above_r = above[15:11];
        above_g = above[10:6];
        left_r  = left[15:11];
        left_g  = left[10:6];
      end
      default: begin
        above_r = above[14:10];
        above_g = above[9:5];
        left_r  = left[14:10];
        left_g  = left[9:5];
      end
    endcase
  end

  always_comb begin
    r = cfg.channel_enable[2] ? noisy_avg(above_r, left_r, raise.red) : 5'd0;
    g = cfg.channel_enable[1] ? noisy_avg(above_g, left_g, raise.green) : 5'd0;
    b = cfg.channel_enable[0] ? noisy_avg(above[4:0], left[4:0], raise.blue) : 5'd0;
  end

  always_comb begin
    unique case (cfg.pixel_format)
      FMT_565: mixed = {r, g, 1'b0, b};
      default: mixed = {1'b0, r, g, b};
    endcase
  end

endmodule

// File: sv/noisy_neighbor_average_pixel_unit.sv
// top level: config registers, two-stage pipeline around the line memory
//
//   channel   handshake                  payload
//   pixel     pixel_valid / pixel_ready  pixel, raise_red, raise_green, raise_blue
//   result    result_valid / result_ready new_pixel
//   cfg       cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one pixel per cycle while the result side is not stalled; a taken request passes stage 1
// (line memory read), then the mix into the new_pixel output register
// reset takes effect at once: no clearing pass, a fill flag zeroes the first line
// a stalled result holds both stages; requests flow again as soon as a slot frees
// cfg_ready is always high; unknown register indexes are dropped
module noisy_neighbor_average_pixel_unit #(
  parameter int LINE_WIDTH = 336
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  logic [15:0]                   pixel,
  input  logic                          raise_red,
  input  logic                          raise_green,
  input  logic                          raise_blue,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [15:0]                   new_pixel,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [nnap_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [nnap_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import nnap_pkg::*;

  cfg_t        cfg;
  logic [15:0] left_pixel;
  logic        s1_valid;
  logic [15:0] s1_left;
  raise_t      s1_raise;
  logic        s1_advance;
  logic        pixel_fire;
  logic [15:0] above;
  logic [15:0] mixed;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_enable <= 3'd7;
      cfg.pixel_format   <= FMT_555;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHANNEL_ENABLE: cfg.channel_enable <= cfg_data[2:0];
        REG_PIXEL_FORMAT:   cfg.pixel_format   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s1_advance  = s1_valid && (!result_valid || result_ready);
  assign pixel_ready = !s1_valid || s1_advance;
  assign pixel_fire  = pixel_valid && pixel_ready;

  nnap_line_mem #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_line_mem (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (pixel_fire),
    .wr_pixel (pixel),
    .above    (above)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel <= 16'h0000;
      s1_valid   <= 1'b0;
    end else begin
      if (pixel_fire) begin
        left_pixel <= pixel;
        s1_valid   <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_fire) begin
      s1_left  <= left_pixel;
      s1_raise <= '{red: raise_red, green: raise_green, blue: raise_blue};
    end
  end

  nnap_pixel_mix u_pixel_mix (
    .cfg   (cfg),
    .raise (s1_raise),
    .above (above),
    .left  (s1_left),
    .mixed (mixed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      new_pixel <= mixed;
    end
  end

`include "noisy_neighbor_average_pixel_unit_assert.svh"

  `NNAP_ASSERT(a_fire_fills_s1, pixel_fire |=> s1_valid, "accepted request not in stage 1")
  `NNAP_ASSERT(a_s1_hold, s1_valid && !s1_advance |=> s1_valid && $stable(s1_left), "s1 not held")
  `NNAP_ASSERT(a_advance_fills_out, s1_advance |=> result_valid, "stage 1 advanced into nothing")
  `NNAP_ASSERT_ALWAYS(a_reset_empty, rst |=> !s1_valid && !result_valid, "not empty after reset")

endmodule

// File: tb/noisy_neighbor_average_pixel_unit_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the noisy neighbor average pixel unit
module noisy_neighbor_average_pixel_unit_tb;
  import nnap_pkg::*;

  localparam int LINE_W         = 336;
  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int N_PHASES       = 7;

  // indexes past the last register, writes there must be dropped
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [15:0] DIRECTED_PIX [14] = '{
    16'h0000, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000, 16'h0020, 16'hFFDF,
    16'h001F, 16'h03E0, 16'h7C00, 16'hF800, 16'h07C0, 16'h7C1F, 16'hF81F
  };
  localparam logic [2:0] DIRECTED_UP [14] = '{
    3'b000, 3'b111, 3'b111, 3'b000, 3'b101, 3'b010, 3'b111,
    3'b000, 3'b110, 3'b001, 3'b011, 3'b100, 3'b111, 3'b000
  };
  localparam logic [15:0] EXTREMES [10] = '{
    16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0020,
    16'hFFDF, 16'h7C1F, 16'hF81F, 16'h03E0, 16'h07C0
  };

  localparam int PHASE_EN    [N_PHASES] = '{7, 0, 5, 2, 6, 1, 7};
  localparam int PHASE_FMT   [N_PHASES] = '{1, 0, 1, 0, 1, 0, 0};
  localparam int PHASE_COUNT [N_PHASES] = '{250, 60, 200, 150, 150, 120, 200};
  localparam bit PHASE_IDLE  [N_PHASES] = '{1, 1, 0, 1, 1, 1, 0};

  typedef struct packed {
    logic [15:0] pix;
    raise_t      up;
  } pixel_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   pixel_valid  = 1'b0;
  logic                   pixel_ready;
  logic [15:0]            pixel        = 16'h0000;
  logic                   raise_red    = 1'b0;
  logic                   raise_green  = 1'b0;
  logic                   raise_blue   = 1'b0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  logic [15:0]            new_pixel;
  logic                   cfg_valid    = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [CFG_DATA_W-1:0]  cfg_data     = '0;

  noisy_neighbor_average_pixel_unit #(.LINE_WIDTH(LINE_W)) dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .raise_red    (raise_red),
    .raise_green  (raise_green),
    .raise_blue   (raise_blue),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .new_pixel    (new_pixel),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state, mirrors the block's line memory and registers
  logic [15:0] line_mem [LINE_W] = '{default: 16'h0000};
  int          line_pos = 0;
  logic [15:0] prev_pixel = 16'h0000;
  logic [2:0]  chan_en = 3'd7;
  logic        fmt_sel = FMT_555;

  pixel_req_t  pixel_reqs_pending [$];
  logic [15:0] stream_log [$];
  logic [15:0] expected_pixels [$];

  int  errors = 0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_cfg_writes = 0;
  int  idle_cycles = 0;
  bit  px_taken = 1'b0;
  bit  idle_on = 1'b1;
  int  send_gap = 0;
  int  stall_left = 0;

  function automatic logic [4:0] step_channel(input logic [4:0] a, input logic [4:0] b,
                                              input logic up);
    int mean;
    mean = (int'(a) + int'(b)) / 2;
    mean = up ? mean + 1 : mean - 1;
    if (mean < 0) mean = 0;
    if (mean > 31) mean = 31;
    return 5'(mean);
  endfunction

  function automatic logic [15:0] predict_pixel(input logic [15:0] above,
                                                input logic [15:0] left, input raise_t up);
    int         rs;
    int         gs;
    logic [4:0] r;
    logic [4:0] g;
    logic [4:0] b;
    rs = (fmt_sel == FMT_565) ? 11 : 10;
    gs = (fmt_sel == FMT_565) ? 6 : 5;
    r = '0;
    g = '0;
    b = '0;
    if (chan_en[2]) r = step_channel(5'(above >> rs), 5'(left >> rs), up.red);
    if (chan_en[1]) g = step_channel(5'(above >> gs), 5'(left >> gs), up.green);
    if (chan_en[0]) b = step_channel(5'(above), 5'(left), up.blue);
    return (16'(r) << rs) | (16'(g) << gs) | 16'(b);
  endfunction

  // monitor: checks results, predicts accepted requests, tracks register writes
  always @(posedge clk) begin : monitor
    logic [15:0] want;
    px_taken = 1'b0;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected new_pixel %h, expected nothing", $time, new_pixel);
        end else begin
          want = expected_pixels.pop_front();
          n_checked++;
          if (new_pixel !== want) begin
            errors++;
            $display("%0t: new_pixel mismatch, expected %h, actual %h", $time, want, new_pixel);
          end
        end
      end
      if (pixel_valid && pixel_ready) begin
        px_taken = 1'b1;
        expected_pixels.push_back(predict_pixel(line_mem[line_pos], prev_pixel,
                                                raise_t'({raise_red, raise_green, raise_blue})));
        line_mem[line_pos] = pixel;
        line_pos = (line_pos == LINE_W - 1) ? 0 : line_pos + 1;
        prev_pixel = pixel;
        n_sent++;
      end
      if (cfg_valid && cfg_ready) begin
        n_cfg_writes++;
        case (cfg_index)
          REG_CHANNEL_ENABLE: chan_en = cfg_data[2:0];
          REG_PIXEL_FORMAT:   fmt_sel = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (pixel_valid && pixel_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("noisy_neighbor_average_pixel_unit_tb failed");
      $finish;
    end
  end

  // request driver with random gap bursts
  always @(negedge clk) begin : driver
    pixel_req_t nxt;
    if (!rst && (!pixel_valid || px_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        pixel_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 12) begin
        send_gap = $urandom_range(1, 11) - 1;
        pixel_valid <= 1'b0;
      end else if (pixel_reqs_pending.size() == 0) begin
        pixel_valid <= 1'b0;
      end else begin
        nxt = pixel_reqs_pending.pop_front();
        pixel_valid <= 1'b1;
        pixel       <= nxt.pix;
        raise_red   <= nxt.up.red;
        raise_green <= nxt.up.green;
        raise_blue  <= nxt.up.blue;
      end
    end
  end

  // result sink with random stall bursts
  always @(negedge clk) begin : sink
    if (stall_left > 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 10) begin
      stall_left = $urandom_range(1, 11) - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  task automatic push_item(input logic [15:0] pix, input logic [2:0] up);
    pixel_reqs_pending.push_back('{pix: pix, up: raise_t'(up)});
    stream_log.push_back(pix);
  endtask

  // hold off until every expected pixel has come back
  task automatic drain();
    while (pixel_reqs_pending.size() != 0 || pixel_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [15:0] pix;
    int          n;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // stream start, saturation at both ends, unused bits, single fields
    for (int i = 0; i < 14; i++) push_item(DIRECTED_PIX[i], DIRECTED_UP[i]);
    drain();
    write_reg(REG_PIXEL_FORMAT, {2'b11, FMT_565});
    end_writes();
    for (int i = 0; i < 8; i++) push_item(DIRECTED_PIX[i], ~DIRECTED_UP[i]);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      write_reg(REG_CHANNEL_ENABLE, 3'(PHASE_EN[p]));
      write_reg(REG_PIXEL_FORMAT, {2'($urandom), 1'(PHASE_FMT[p])});
      if (p == 2) begin
        write_reg(REG_SPARE_A, 3'($urandom));
        write_reg(REG_SPARE_B, 3'($urandom));
      end
      end_writes();
      idle_on = PHASE_IDLE[p];
      for (int k = 0; k < PHASE_COUNT[p]; k++) begin
        n = stream_log.size();
        // repeats and copies from one line up give long runs of equal neighbors
        case ($urandom_range(0, 9))
          0, 1:    pix = EXTREMES[$urandom_range(0, 9)];
          2, 3:    pix = stream_log[n - 1];
          4, 5:    pix = (n >= LINE_W) ? stream_log[n - LINE_W] : 16'($urandom);
          default: pix = 16'($urandom);
        endcase
        push_item(pix, 3'($urandom));
      end
    end

    drain();
    $display("run covered %0d pixel requests, %0d results checked, %0d register writes",
             n_sent, n_checked, n_cfg_writes);
    $display("555 and 565 layouts, six channel masks, about %0d full lines, stalls both sides",
             n_sent / LINE_W);
    if (errors == 0) begin
      $display("noisy_neighbor_average_pixel_unit_tb passed");
    end else begin
      $display("noisy_neighbor_average_pixel_unit_tb failed");
    end
    $finish;
  end

endmodule
